// File: src/keyboard_scancode_line_editor_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keyboard scan-code line editor
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_SCANCODE_LINE_EDITOR_DEFINES_SVH
`define KEYBOARD_SCANCODE_LINE_EDITOR_DEFINES_SVH

// Assertion sampled on clk, off while rst_n is low.
`define KSLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion sampled on clk that also holds during reset.
`define KSLE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/ksle_pkg.sv
// ----------------------------------------------------------------------------
// ksle_pkg
// Types, scan codes and key tables of the scan-code line editor.
// ----------------------------------------------------------------------------
package ksle_pkg;

  localparam int SCREENS    = 3;
  localparam int LINE_LIMIT = 127;
  localparam int NKEYS      = 50;
  localparam int NLETTERS   = 26;
  localparam int CNT_W      = $clog2(LINE_LIMIT + 1);
  localparam int KEY_IDX_W  = $clog2(NKEYS);

  localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
  localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] SC_ALT_MAKE     = 8'h38;
  localparam logic [7:0] SC_ALT_BREAK    = 8'hB8;
  localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
  localparam logic [7:0] SC_F1           = 8'h3B;
  localparam logic [7:0] SC_F3           = 8'h3D;

  localparam logic [6:0] ASCII_BS = 7'd8;
  localparam logic [6:0] ASCII_NL = 7'd10;

  typedef enum logic [2:0] {
    EV_CHAR    = 3'd0,
    EV_BACK    = 3'd1,
    EV_LINE    = 3'd2,
    EV_SCREEN  = 3'd3,
    EV_COMMAND = 3'd4,
    EV_DROPPED = 3'd5
  } event_t;

  typedef struct packed {
    logic                 found;
    logic                 letter;
    logic [KEY_IDX_W-1:0] idx;
    logic [6:0]           plain_ch;
    logic [6:0]           shift_ch;
  } key_hit_t;

  typedef struct packed {
    logic       valid;
    event_t     ev;
    logic [6:0] ch;
    logic [1:0] screen;
    logic [6:0] pos;
    logic [6:0] len;
    logic [2:0] cmd;
  } result_t;

  localparam logic [7:0] KEY_CODES [NKEYS] = '{
    8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24,
    8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14,
    8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C, 8'h02, 8'h03, 8'h04, 8'h05,
    8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h1A, 8'h1B,
    8'h27, 8'h28, 8'h29, 8'h2B, 8'h33, 8'h34, 8'h35, 8'h39, 8'h0E, 8'h1C
  };

  localparam logic [7:0] PLAIN_CHARS [NKEYS] = '{
    "a", "b", "c", "d", "e", "f", "g", "h", "i", "j",
    "k", "l", "m", "n", "o", "p", "q", "r", "s", "t",
    "u", "v", "w", "x", "y", "z", "1", "2", "3", "4",
    "5", "6", "7", "8", "9", "0", "-", "=", "[", "]",
    ";", 8'h27, 8'h60, 8'h5C, ",", ".", "/", 8'h20, 8'h08, 8'h0A
  };

  localparam logic [7:0] SHIFT_CHARS [NKEYS] = '{
    "A", "B", "C", "D", "E", "F", "G", "H", "I", "J",
    "K", "L", "M", "N", "O", "P", "Q", "R", "S", "T",
    "U", "V", "W", "X", "Y", "Z", "!", "@", "#", "$",
    "%", "^", "&", "*", "(", ")", "_", "+", "{", "}",
    ":", 8'h22, "~", "|", "<", ">", "?", 8'h20, 8'h08, 8'h0A
  };

endpackage

// File: src/ksle_key_lookup.sv
// ----------------------------------------------------------------------------
// ksle_key_lookup
// Parallel match of a scan byte against the key table, with both characters.
// ----------------------------------------------------------------------------
module ksle_key_lookup
  import ksle_pkg::*;
(
  input  logic [7:0] scan_byte,
  output key_hit_t   hit
);

  logic                 found;
  logic [KEY_IDX_W-1:0] idx;

  // Match every entry at once; the last match wins.
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int k = 0; k < NKEYS; k++) begin
      if (KEY_CODES[k] == scan_byte) begin
        found = 1'b1;
        idx   = KEY_IDX_W'(k);
      end
    end
  end

  assign hit.found    = found;
  assign hit.idx      = idx;
  assign hit.letter   = (idx < KEY_IDX_W'(NLETTERS));
  assign hit.plain_ch = PLAIN_CHARS[idx][6:0];
  assign hit.shift_ch = SHIFT_CHARS[idx][6:0];

endmodule

// File: src/ksle_edit_core.sv
// ----------------------------------------------------------------------------
// ksle_edit_core
// Modifier, screen and line-count state with the per-byte event decision.
// ----------------------------------------------------------------------------
module ksle_edit_core
  import ksle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] scan_byte,
  input  key_hit_t   hit,
  output result_t    res
);

  localparam logic [KEY_IDX_W-1:0] KEY_C  = KEY_IDX_W'(2);
  localparam logic [KEY_IDX_W-1:0] KEY_L  = KEY_IDX_W'(11);
  localparam logic [KEY_IDX_W-1:0] KEY_R  = KEY_IDX_W'(17);
  localparam logic [KEY_IDX_W-1:0] KEY_T  = KEY_IDX_W'(19);
  localparam logic [KEY_IDX_W-1:0] KEY_Z  = KEY_IDX_W'(25);
  localparam logic [CNT_W-1:0]     LIMIT  = CNT_W'(LINE_LIMIT);

  logic             ctrl_r, ctrl_nxt;
  logic             lshift_r, lshift_nxt;
  logic             rshift_r, rshift_nxt;
  logic             alt_r, alt_nxt;
  logic             caps_r, caps_nxt;
  logic [1:0]       screen_r, screen_nxt;
  logic [CNT_W-1:0] count_r [SCREENS];
  logic [CNT_W-1:0] count_nxt;
  logic             count_we;

  logic             upper;
  logic [6:0]       ch;
  logic             cmd_hit;
  logic [2:0]       cmd_code;
  logic [CNT_W-1:0] cnt;
  logic [1:0]       target;

  always_comb begin
    unique case (hit.idx)
      KEY_R:   begin cmd_hit = 1'b1; cmd_code = 3'd0; end
      KEY_Z:   begin cmd_hit = 1'b1; cmd_code = 3'd1; end
      KEY_C:   begin cmd_hit = 1'b1; cmd_code = 3'd2; end
      KEY_T:   begin cmd_hit = 1'b1; cmd_code = 3'd3; end
      KEY_L:   begin cmd_hit = 1'b1; cmd_code = 3'd4; end
      default: begin cmd_hit = 1'b0; cmd_code = 3'd0; end
    endcase
  end

  assign upper  = (lshift_r | rshift_r) ^ (hit.letter & caps_r);
  assign ch     = upper ? hit.shift_ch : hit.plain_ch;
  assign target = 2'(scan_byte - SC_F1);

  always_comb begin
    cnt = count_r[screen_r];
    if (cnt > LIMIT) begin
      cnt = LIMIT;
    end
  end

  always_comb begin
    ctrl_nxt   = ctrl_r;
    lshift_nxt = lshift_r;
    rshift_nxt = rshift_r;
    alt_nxt    = alt_r;
    caps_nxt   = caps_r;
    screen_nxt = screen_r;
    count_nxt  = cnt;
    count_we   = 1'b0;
    res        = '0;
    res.ev     = EV_CHAR;

    if (scan_byte == SC_CTRL_MAKE)    ctrl_nxt   = 1'b1;
    if (scan_byte == SC_CTRL_BREAK)   ctrl_nxt   = 1'b0;
    if (scan_byte == SC_LSHIFT_MAKE)  lshift_nxt = 1'b1;
    if (scan_byte == SC_LSHIFT_BREAK) lshift_nxt = 1'b0;
    if (scan_byte == SC_RSHIFT_MAKE)  rshift_nxt = 1'b1;
    if (scan_byte == SC_RSHIFT_BREAK) rshift_nxt = 1'b0;
    if (scan_byte == SC_ALT_MAKE)     alt_nxt    = 1'b1;
    if (scan_byte == SC_ALT_BREAK)    alt_nxt    = 1'b0;
    if (scan_byte == SC_CAPS_MAKE)    caps_nxt   = ~caps_r;

    priority if (alt_r && scan_byte >= SC_F1 && scan_byte <= SC_F3) begin
      if (32'(target) < SCREENS) begin
        screen_nxt = target;
        res.valid  = 1'b1;
        res.ev     = EV_SCREEN;
      end
    end else if (scan_byte[7] || !hit.found) begin
      // release bytes and unknown keys give no result
    end else if (ctrl_r && cmd_hit) begin
      res.valid = 1'b1;
      res.ev    = EV_COMMAND;
      res.cmd   = cmd_code;
    end else if (ch == ASCII_BS) begin
      if (cnt != '0) begin
        count_nxt = cnt - 1'b1;
        count_we  = 1'b1;
        res.valid = 1'b1;
        res.ev    = EV_BACK;
        res.ch    = ASCII_BS;
        res.pos   = 7'(cnt - 1'b1);
      end
    end else if (ch == ASCII_NL) begin
      count_nxt = '0;
      count_we  = 1'b1;
      res.valid = 1'b1;
      res.ev    = EV_LINE;
      res.ch    = ASCII_NL;
      res.pos   = 7'(cnt);
      res.len   = (cnt < LIMIT) ? 7'(cnt + 1'b1) : 7'(cnt);
    end else if (cnt >= LIMIT) begin
      res.valid = 1'b1;
      res.ev    = EV_DROPPED;
      res.ch    = ch;
    end else begin
      count_nxt = cnt + 1'b1;
      count_we  = 1'b1;
      res.valid = 1'b1;
      res.ev    = EV_CHAR;
      res.ch    = ch;
      res.pos   = 7'(cnt);
    end

    res.screen = screen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= 1'b0;
      lshift_r <= 1'b0;
      rshift_r <= 1'b0;
      alt_r    <= 1'b0;
      caps_r   <= 1'b0;
      screen_r <= 2'd0;
      for (int s = 0; s < SCREENS; s++) begin
        count_r[s] <= '0;
      end
    end else if (step) begin
      ctrl_r   <= ctrl_nxt;
      lshift_r <= lshift_nxt;
      rshift_r <= rshift_nxt;
      alt_r    <= alt_nxt;
      caps_r   <= caps_nxt;
      screen_r <= screen_nxt;
      if (count_we) begin
        count_r[screen_r] <= count_nxt;
      end
    end
  end

endmodule

// File: src/keyboard_scancode_line_editor.sv
// ----------------------------------------------------------------------------
// keyboard_scancode_line_editor
// Scan-code set 1 to ASCII translator with per-screen line counting.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one raw scan byte per transfer on the in_ stream. Each byte updates
//   the ctrl, shift, alt and caps-lock state and gives at most one event on
//   the out_ stream: a character, backspace, completed line, screen switch,
//   ctrl command or a character dropped on a full line. Bytes that cause no
//   event (releases, modifiers, unknown codes) produce no output transfer.
//   Path: an accepted byte is held in the input register and decoded against
//   the state there; its event is registered in the result register for out_.
//   Throughput: one byte per cycle unless out_ stalls, set by the single
//   decode stage that updates the modifier and line-count state it reads.
//   Stall: while out_tvalid is high and out_tready low, the output and the
//   decode stage hold; one more byte may still be taken into the input
//   register, then in_tready drops until the receiver takes the result.
//   Reset (rst_n low, synchronous): clear both pipeline stages, all
//   modifiers, caps lock, the active screen (screen 0) and every line count.
// ----------------------------------------------------------------------------
module keyboard_scancode_line_editor
  import ksle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] scan_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [2:0] event_res, [9:3] char_code,
                                  // [11:10] screen, [18:12] position,
                                  // [25:19] line_length, [28:26] command
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  result_t    out_r;
  logic       advance;
  logic       step;
  key_hit_t   hit;
  result_t    res;

  // Move the decode stage whenever the output register is free or drains.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance || !s1_valid_r;
  assign step      = s1_valid_r && advance;

  // Input register: load a transfer, or empty when the byte moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  ksle_key_lookup u_lookup (
    .scan_byte (s1_byte_r),
    .hit       (hit)
  );

  ksle_edit_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .scan_byte (s1_byte_r),
    .hit       (hit),
    .res       (res)
  );

  // Result register: drop bytes that give no event.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.cmd, out_r.len, out_r.pos, out_r.screen,
                       out_r.ch, out_r.ev};

endmodule

// File: src/ksle_checker.sv
// ----------------------------------------------------------------------------
// ksle_checker
// Port-level assertions of the scan-code line editor, bound to the top level.
// ----------------------------------------------------------------------------
`include "keyboard_scancode_line_editor_defines.svh"

module ksle_checker
  import ksle_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  logic [2:0] ev;
  assign ev = out_tdata[2:0];

  `KSLE_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid, "output valid after reset")
  `KSLE_ASSERT(a_stall_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `KSLE_ASSERT(a_event_legal, out_tvalid |-> (ev <= 3'd5) && (32'(out_tdata[11:10]) < SCREENS) && (out_tdata[31:29] == 3'b000), "illegal event or screen")
  `KSLE_ASSERT(a_switch_fields, out_tvalid && (ev == 3'd3) |-> (out_tdata[9:3] == 7'd0) && (out_tdata[28:12] == 17'd0), "screen switch carries data")
  `KSLE_ASSERT(a_nl_code, out_tvalid && (ev == 3'd2) |-> (out_tdata[9:3] == 7'd10) && (out_tdata[28:26] == 3'd0), "line event without newline")

endmodule

bind keyboard_scancode_line_editor ksle_checker u_ksle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
